### rtl/core/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

    // Register indexes on the configuration write channel.
    localparam logic [2:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [2:0] CFG_CARE_MASK    = 3'd2;
    localparam logic [2:0] CFG_PATTERN_LEN  = 3'd3;
    localparam logic [2:0] CFG_SEARCH_MODE  = 3'd4;
    localparam logic [2:0] CFG_SEARCH_OFF   = 3'd5;

    // Search modes. The unused code behaves as MODE_ALL.
    localparam logic [1:0] MODE_ALL   = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_LAST  = 2'd2;

    // Result kinds.
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Number of pattern byte slots held in the pattern registers.
    localparam int PATTERN_SLOTS = 16;

    // Depth of the result queue and its index widths.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic        kind;
        logic        found;
        logic [31:0] offset;
        logic [31:0] total;
        logic        eor;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/masked_byte_pattern_scanner.sv
`default_nettype none

// Channel     Dir  Handshake                  Payload
// s_axis      in   tvalid/tready              tdata = data_byte, tlast = final_byte
// m_axis      out  tvalid/tready              tdata = found/offset/total,
//                                             tuser = report_kind, tlast = end_of_run
// cfg         in   i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle. A byte is registered, then compared and
// counted in the next cycle, and its results are written to the result queue.
// A final byte with a hit in all mode gives two results, which leave the
// eight-entry queue one per cycle while m_axis tready is high. s_axis tready
// drops while the queue holds more than four results. Reset clears the run
// state, the queue and loads the register reset values; cfg is always ready.
module masked_byte_pattern_scanner #(
    parameter int PATTERN_MAX = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tlast,

    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [0] found, [32:1] match_offset,
                                          // [64:33] match_total, [71:65] zero
    output logic        o_m_axis_tuser,   // [0] report_kind
    output logic        o_m_axis_tlast,

    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data
);

    localparam int CMP_N  = (PATTERN_MAX < mbps_pkg::PATTERN_SLOTS) ?
                            PATTERN_MAX : mbps_pkg::PATTERN_SLOTS;
    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int CMPW   = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    // Configuration registers.
    logic [127:0]           r_pattern;
    logic [15:0]            r_care;
    logic [4:0]             r_length;
    logic [1:0]             r_mode;
    logic [31:0]            r_search_off;

    // Input register.
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;

    // Run state.
    logic [7:0]             r_window [PATTERN_MAX];
    logic [FILL_W-1:0]      r_fill;
    logic [OFFSET_BITS-1:0] r_bytes_seen;
    logic [31:0]            r_matches;
    logic                   r_have;
    logic [OFFSET_BITS-1:0] r_kept;

    // Result queue.
    mbps_pkg::t_result      r_queue [mbps_pkg::QUEUE_DEPTH];
    logic [mbps_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [mbps_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [mbps_pkg::QCNT_W-1:0] r_count;

    // Next values of the processing stage.
    logic [7:0]             n_window [PATTERN_MAX];
    logic [FILL_W-1:0]      n_fill;
    logic [OFFSET_BITS-1:0] n_bytes_seen;
    logic [31:0]            n_matches;
    logic                   n_have;
    logic [OFFSET_BITS-1:0] n_kept;
    logic [4:0]             len;
    logic                   hit;
    logic [OFFSET_BITS-1:0] start;
    logic [CMPW-1:0]        start_ext;
    logic [CMPW-1:0]        kept_ext;
    logic                   push_match;
    logic                   push_summary;
    mbps_pkg::t_result      match_res;
    mbps_pkg::t_result      summary_res;
    logic                   in_accept;
    logic                   out_pop;
    logic [mbps_pkg::QCNT_W-1:0] push_n;
    logic [mbps_pkg::QCNT_W-1:0] n_count;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_pop         = o_m_axis_tvalid && i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;
    // A byte in the input register and a new byte each add at most two results.
    assign o_s_axis_tready = (r_count <= mbps_pkg::QCNT_W'(mbps_pkg::QUEUE_DEPTH - 4));
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {7'b0, r_queue[r_rd_ptr].total, r_queue[r_rd_ptr].offset,
                              r_queue[r_rd_ptr].found};
    assign o_m_axis_tuser  = r_queue[r_rd_ptr].kind;
    assign o_m_axis_tlast  = r_queue[r_rd_ptr].eor;

    // Pattern length in use: zero counts as one, and longer lengths are clamped to the available slots.
    always_comb begin
        if (r_length == 5'd0) begin
            len = 5'd1;
        end else if (r_length > 5'(CMP_N)) begin
            len = 5'(CMP_N);
        end else begin
            len = r_length;
        end
    end

    // Window shift, masked compare and hit bookkeeping.
    always_comb begin
        logic [7:0] sel;
        logic       ok;
        n_window[0] = r_in_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_window[k] = r_window[k-1];
        end
        n_fill = (r_fill == FILL_W'(PATTERN_MAX)) ? r_fill : r_fill + FILL_W'(1);

        // Pattern byte i lines up with window slot len-1-i.
        ok = (int'(n_fill) >= int'(len));
        for (int i = 0; i < CMP_N; i++) begin
            sel = '0;
            for (int j = 0; j < CMP_N; j++) begin
                if (j + i + 1 == int'(len)) begin
                    sel = sel | n_window[j];
                end
            end
            if ((i < int'(len)) && r_care[i] && (sel != r_pattern[8*i +: 8])) begin
                ok = 1'b0;
            end
        end
        hit = ok;

        start        = r_bytes_seen - OFFSET_BITS'(len - 5'd1);
        start_ext    = CMPW'(start);
        n_bytes_seen = r_bytes_seen + OFFSET_BITS'(1);
        n_matches    = r_matches;
        n_have       = r_have;
        n_kept       = r_kept;
        push_match   = 1'b0;
        if (hit) begin
            if (r_matches != '1) begin
                n_matches = r_matches + 32'd1;
            end
            case (r_mode)
                mbps_pkg::MODE_FIRST: begin
                    if (!r_have && (start_ext >= CMPW'(r_search_off))) begin
                        n_have = 1'b1;
                        n_kept = start;
                    end
                end
                mbps_pkg::MODE_LAST: begin
                    if (start_ext <= CMPW'(r_search_off)) begin
                        n_have = 1'b1;
                        n_kept = start;
                    end
                end
                default: begin
                    if (!r_have) begin
                        n_have = 1'b1;
                        n_kept = start;
                    end
                    push_match = 1'b1;
                end
            endcase
        end
        push_summary = r_in_last;
        kept_ext     = n_have ? CMPW'(n_kept) : '0;

        match_res.kind   = mbps_pkg::KIND_MATCH;
        match_res.found  = 1'b1;
        match_res.offset = start_ext[31:0];
        match_res.total  = n_matches;
        match_res.eor    = !r_in_last;

        summary_res.kind   = mbps_pkg::KIND_SUMMARY;
        summary_res.found  = n_have;
        summary_res.offset = kept_ext[31:0];
        summary_res.total  = n_matches;
        summary_res.eor    = 1'b1;
    end

    // Queue occupancy after this cycle's pushes and pop.
    always_comb begin
        push_n = '0;
        if (r_in_valid) begin
            push_n = mbps_pkg::QCNT_W'(push_match) + mbps_pkg::QCNT_W'(push_summary);
        end
        n_count = r_count + push_n - mbps_pkg::QCNT_W'(out_pop);
    end

    // Control, configuration and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= '0;
            r_care       <= 16'hFFFF;
            r_length     <= 5'd1;
            r_mode       <= mbps_pkg::MODE_ALL;
            r_search_off <= '0;
            r_in_valid   <= 1'b0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_window[k] <= '0;
            end
            r_fill       <= '0;
            r_bytes_seen <= '0;
            r_matches    <= '0;
            r_have       <= 1'b0;
            r_kept       <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            // Register writes.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mbps_pkg::CFG_PATTERN_LOW:  r_pattern[63:0]   <= i_cfg_data;
                    mbps_pkg::CFG_PATTERN_HIGH: r_pattern[127:64] <= i_cfg_data;
                    mbps_pkg::CFG_CARE_MASK:    r_care            <= i_cfg_data[15:0];
                    mbps_pkg::CFG_PATTERN_LEN:  r_length          <= i_cfg_data[4:0];
                    mbps_pkg::CFG_SEARCH_MODE:  r_mode            <= i_cfg_data[1:0];
                    mbps_pkg::CFG_SEARCH_OFF:   r_search_off      <= i_cfg_data[31:0];
                    default: ;
                endcase
            end

            r_in_valid <= in_accept;

            // The final byte clears the run as its summary is queued.
            if (r_in_valid) begin
                if (r_in_last) begin
                    for (int k = 0; k < PATTERN_MAX; k++) begin
                        r_window[k] <= '0;
                    end
                    r_fill       <= '0;
                    r_bytes_seen <= '0;
                    r_matches    <= '0;
                    r_have       <= 1'b0;
                    r_kept       <= '0;
                end else begin
                    r_window     <= n_window;
                    r_fill       <= n_fill;
                    r_bytes_seen <= n_bytes_seen;
                    r_matches    <= n_matches;
                    r_have       <= n_have;
                    r_kept       <= n_kept;
                end
            end

            r_wr_ptr <= r_wr_ptr + mbps_pkg::QPTR_W'(push_n);
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + mbps_pkg::QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Result queue writes: a match report goes ahead of the summary.
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            if (push_match) begin
                r_queue[r_wr_ptr] <= match_res;
                if (push_summary) begin
                    r_queue[r_wr_ptr + mbps_pkg::QPTR_W'(1)] <= summary_res;
                end
            end else if (push_summary) begin
                r_queue[r_wr_ptr] <= summary_res;
            end
        end
    end

endmodule

`default_nettype wire

### bench/testbench.sv
module testbench;
    import mbps_pkg::*;

    localparam int PATTERN_MAX  = 16;
    localparam int ITEM_TARGET  = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int REPORT_LIMIT = 10;

    // The fourth mode code has no name in the package; it scans like all mode.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [7:0] value;
        logic       closes;
    } t_byte_item;

    // Clock, reset and the signals around the block.
    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_data   = '0;
    logic        in_last   = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_PATTERN_LOW;
    logic [63:0] cfg_data  = '0;
    wire         in_ready;
    wire         out_valid;
    wire  [71:0] out_data;
    wire         out_kind;
    wire         out_last;
    wire         cfg_ready;

    masked_byte_pattern_scanner #(
        .PATTERN_MAX(PATTERN_MAX),
        .OFFSET_BITS(32)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(in_valid),
        .o_s_axis_tready(in_ready),
        .i_s_axis_tdata (in_data),
        .i_s_axis_tlast (in_last),
        .o_m_axis_tvalid(out_valid),
        .i_m_axis_tready(out_ready),
        .o_m_axis_tdata (out_data),
        .o_m_axis_tuser (out_kind),
        .o_m_axis_tlast (out_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // Bytes waiting to be sent and reports waiting to arrive.
    t_byte_item byte_queue[$];
    t_result    expected_reports[$];

    // Register copies as the block should hold them.
    logic [63:0] pat_low;
    logic [63:0] pat_high;
    logic [15:0] care_bits;
    logic [4:0]  pat_len_reg;
    logic [1:0]  scan_mode;
    logic [31:0] bound_offset;

    // Run state of the scan.
    logic [7:0]  window [PATTERN_MAX];
    logic [31:0] byte_count;
    logic [31:0] hit_count;
    logic [31:0] kept_start;
    logic        kept_valid;
    int          window_fill;

    // Idle rates, the long output hold and the run statistics.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic long_hold_armed = 1'b0;
    int   hold_left = 0;
    int   items_queued = 0;
    int   n_inputs = 0;
    int   n_match_reports = 0;
    int   n_summaries = 0;
    int   n_input_stalls = 0;
    int   mismatch_count = 0;

    function automatic int used_len();
        int n;
        n = pat_len_reg;
        if (n == 0) begin
            n = 1;
        end
        if (n > PATTERN_MAX) begin
            n = PATTERN_MAX;
        end
        return n;
    endfunction

    function automatic logic [7:0] pat_byte(int i);
        return (i < 8) ? pat_low[8*i +: 8] : pat_high[8*(i-8) +: 8];
    endfunction

    task automatic clear_run();
        int i;
        for (i = 0; i < PATTERN_MAX; i++) begin
            window[i] = 8'h00;
        end
        byte_count  = '0;
        hit_count   = '0;
        kept_start  = '0;
        kept_valid  = 1'b0;
        window_fill = 0;
    endtask

    // Shift one byte into the window, compare and queue the reports it causes.
    task automatic scan_byte(input logic [7:0] b, input logic closes);
        int          len;
        int          i;
        logic        hit;
        logic [31:0] pos;
        logic [31:0] start;
        t_result     r;
        len = used_len();
        pos = byte_count;
        for (i = PATTERN_MAX - 1; i > 0; i--) begin
            window[i] = window[i-1];
        end
        window[0] = b;
        if (window_fill < PATTERN_MAX) begin
            window_fill++;
        end
        byte_count++;

        // Pattern byte i lines up with window slot len-1-i; skipped bytes always agree.
        hit = (window_fill >= len);
        for (i = 0; i < len; i++) begin
            if (care_bits[i] && window[len-1-i] != pat_byte(i)) begin
                hit = 1'b0;
            end
        end

        if (hit) begin
            start = pos - 32'(len - 1);
            if (hit_count != '1) begin
                hit_count++;
            end
            case (scan_mode)
                MODE_FIRST: begin
                    if (!kept_valid && start >= bound_offset) begin
                        kept_valid = 1'b1;
                        kept_start = start;
                    end
                end
                MODE_LAST: begin
                    if (start <= bound_offset) begin
                        kept_valid = 1'b1;
                        kept_start = start;
                    end
                end
                default: begin
                    if (!kept_valid) begin
                        kept_valid = 1'b1;
                        kept_start = start;
                    end
                    r.kind   = KIND_MATCH;
                    r.found  = 1'b1;
                    r.offset = start;
                    r.total  = hit_count;
                    r.eor    = !closes;
                    expected_reports.push_back(r);
                end
            endcase
        end

        // The closing byte adds the buffer summary and starts a fresh run.
        if (closes) begin
            r.kind   = KIND_SUMMARY;
            r.found  = kept_valid;
            r.offset = kept_valid ? kept_start : '0;
            r.total  = hit_count;
            r.eor    = 1'b1;
            expected_reports.push_back(r);
            clear_run();
        end
    endtask

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s: expected kind %0d found %0d offset %0d total %0d last %0d",
                     what, want.kind, want.found, want.offset, want.total, want.eor);
            $display("    actual kind %0d found %0d offset %0d total %0d last %0d",
                     got.kind, got.found, got.offset, got.total, got.eor);
        end
    endtask

    // One register write transaction; the local copy follows once it is taken.
    task automatic set_register(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PATTERN_LOW:  pat_low      = value;
            CFG_PATTERN_HIGH: pat_high     = value;
            CFG_CARE_MASK:    care_bits    = value[15:0];
            CFG_PATTERN_LEN:  pat_len_reg  = value[4:0];
            CFG_SEARCH_MODE:  scan_mode    = value[1:0];
            CFG_SEARCH_OFF:   bound_offset = value[31:0];
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] value, input logic closes);
        t_byte_item item;
        item.value  = value;
        item.closes = closes;
        byte_queue.push_back(item);
        items_queued++;
    endtask

    // A buffer of n bytes: planted pattern copies with random wildcard bytes,
    // cut-off copies, and filler that often repeats pattern bytes.
    task automatic queue_buffer(input int n, input logic closes);
        int len;
        int plen;
        int j;
        int k;
        len = used_len();
        k = 0;
        while (k < n) begin
            if (n - k >= len && $urandom_range(2) == 0) begin
                plen = ($urandom_range(4) == 0) ? $urandom_range(len - 1) : len;
                for (j = 0; j < plen; j++) begin
                    push_byte(care_bits[j] ? pat_byte(j) : 8'($urandom_range(255)),
                              closes && (k == n - 1));
                    k++;
                end
            end else begin
                push_byte($urandom_range(1) ? pat_byte($urandom_range(len - 1))
                                            : 8'($urandom_range(255)),
                          closes && (k == n - 1));
                k++;
            end
        end
    endtask

    // Wait until every byte is taken and every report has come, then let the
    // pipeline run empty in case the last bytes caused nothing.
    task automatic settle();
        do @(negedge i_clk); while (byte_queue.size() != 0 || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // New random settings, then one to three buffers; the last one may stay
    // open so that a run carries over into the next settings.
    task automatic random_phase();
        int span;
        int nbuf;
        int b;
        int pick;
        span = $urandom_range(40, 6);
        pick = $urandom_range(7);
        set_register(CFG_PATTERN_LOW, (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom});
        pick = $urandom_range(7);
        set_register(CFG_PATTERN_HIGH, (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom});
        pick = $urandom_range(7);
        set_register(CFG_CARE_MASK, (pick == 0) ? 64'h0 : (pick == 1) ? 64'hFFFF
                                                        : 64'($urandom_range(16'hFFFF)));
        pick = $urandom_range(9);
        set_register(CFG_PATTERN_LEN, (pick == 0) ? 64'd0 : (pick == 1) ? 64'($urandom_range(31, 17))
                                    : (pick == 2) ? 64'd16 : 64'($urandom_range(6, 1)));
        set_register(CFG_SEARCH_MODE, 64'($urandom_range(3)));
        pick = $urandom_range(5);
        set_register(CFG_SEARCH_OFF, (pick == 0) ? 64'h0 : (pick == 1) ? 64'hFFFF_FFFF
                                                       : 64'($urandom_range(span)));
        nbuf = $urandom_range(3, 1);
        for (b = 0; b < nbuf; b++) begin
            queue_buffer($urandom_range(span, 1), (b < nbuf - 1) || ($urandom_range(5) != 0));
        end
        settle();
    endtask

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Byte sender: presents the oldest waiting byte, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                byte_queue.delete(0);
            end
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= byte_queue[0].value;
                in_last  <= byte_queue[0].closes;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Report receiver: random stalls, plus one long hold when armed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (long_hold_armed) begin
                hold_left = LONG_HOLD;
                long_hold_armed <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Monitor: check each report transaction and predict from each byte transaction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (in_valid && !in_ready) begin
                n_input_stalls++;
            end
            if (out_valid && out_ready) begin
                got.kind   = out_kind;
                got.found  = out_data[0];
                got.offset = out_data[32:1];
                got.total  = out_data[64:33];
                got.eor    = out_last;
                if (expected_reports.size() == 0) begin
                    note_mismatch("unexpected report", '0, got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        note_mismatch("report mismatch", want, got);
                    end
                end
                if (got.kind == KIND_SUMMARY) begin
                    n_summaries++;
                end else begin
                    n_match_reports++;
                end
            end
            if (in_valid && in_ready) begin
                scan_byte(in_data, in_last);
                n_inputs++;
            end
        end
    end

    // Watchdog.
    initial begin
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
            @(posedge i_clk);
        end
        $display("Timed out after %0d cycles with %0d reports outstanding",
                 CYCLE_LIMIT, expected_reports.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        pat_low      = '0;
        pat_high     = '0;
        care_bits    = 16'hFFFF;
        pat_len_reg  = 5'd1;
        scan_mode    = MODE_ALL;
        bound_offset = '0;
        clear_run();
        send_idle_pct = 23;
        recv_idle_pct = 85;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a zero byte is a one-byte hit, including on the
        // closing byte; then a one-byte buffer that misses.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        settle();

        // Buffer shorter than the pattern: even all wildcards cannot hit.
        set_register(CFG_CARE_MASK, 64'h0);
        set_register(CFG_PATTERN_LEN, 64'd4);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h43, 1'b1);
        settle();

        // Pattern 41 ?? 43 in all mode; the closing byte completes a hit.
        set_register(CFG_PATTERN_LOW, 64'h43_00_41);
        set_register(CFG_PATTERN_HIGH, '1);
        set_register(CFG_CARE_MASK, 64'h0005);
        set_register(CFG_PATTERN_LEN, 64'd3);
        push_byte(8'h41, 1'b0);
        push_byte(8'h99, 1'b0);
        push_byte(8'h43, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'h43, 1'b1);
        settle();

        // First mode skips the hit before the bound and keeps the next one.
        set_register(CFG_SEARCH_MODE, MODE_FIRST);
        set_register(CFG_SEARCH_OFF, 64'd1);
        push_byte(8'h41, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h43, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h43, 1'b1);
        settle();

        // Last mode with the highest bound accepts any hit.
        set_register(CFG_SEARCH_MODE, MODE_LAST);
        set_register(CFG_SEARCH_OFF, 64'hFFFF_FFFF);
        push_byte(8'h41, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h43, 1'b1);
        settle();

        // Unused mode code scans as all mode; length zero counts as one.
        set_register(CFG_SEARCH_MODE, MODE_UNUSED);
        set_register(CFG_PATTERN_LEN, 64'd0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b1);
        settle();

        // Random part: slow receiver first, then slow sender, then full rate.
        while (items_queued < ITEM_TARGET / 3) begin
            random_phase();
        end
        send_idle_pct = 85;
        recv_idle_pct = 23;
        while (items_queued < 2 * ITEM_TARGET / 3) begin
            random_phase();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Every byte hits while the receiver holds off, so the result queue
        // fills and the input has to stall.
        set_register(CFG_CARE_MASK, 64'h0);
        set_register(CFG_PATTERN_LEN, 64'd1);
        set_register(CFG_SEARCH_MODE, MODE_ALL);
        long_hold_armed <= 1'b1;
        queue_buffer(60, 1'b1);
        settle();

        while (items_queued < ITEM_TARGET) begin
            random_phase();
        end
        settle();

        $display("Scanned %0d bytes under random patterns, wildcards, lengths and modes;",
                 n_inputs);
        $display("checked %0d hit reports and %0d buffer summaries, input stalled %0d cycles.",
                 n_match_reports, n_summaries, n_input_stalls);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
